/* sv/complex_number_alu_defines.svh */
// assertion macros shared by the complex arithmetic unit
`ifndef COMPLEX_NUMBER_ALU_DEFINES_SVH
`define COMPLEX_NUMBER_ALU_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define CNA_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("complex_number_alu: same-cycle check failed");

// next-cycle implication, clocked on clk, off during rst
`define CNA_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("complex_number_alu: next-cycle check failed");

`endif

/* sv/cna_pkg.sv */
// shared codes, constants and the arctangent table of the complex arithmetic unit
package cna_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_ADD = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB = 4'd1;
  localparam logic [OP_W-1:0] OP_NEG = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV = 4'd4;
  localparam logic [OP_W-1:0] OP_ABS = 4'd5;
  localparam logic [OP_W-1:0] OP_ARG = 4'd6;
  localparam logic [OP_W-1:0] OP_INC = 4'd7;
  localparam logic [OP_W-1:0] OP_DEC = 4'd8;
  localparam logic [OP_W-1:0] OP_GT  = 4'd9;
  localparam logic [OP_W-1:0] OP_LT  = 4'd10;
  localparam logic [OP_W-1:0] OP_GE  = 4'd11;
  localparam logic [OP_W-1:0] OP_LE  = 4'd12;
  localparam logic [OP_W-1:0] OP_EQ  = 4'd13;
  localparam logic [OP_W-1:0] OP_NE  = 4'd14;

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_DIVZ = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT  = 2'd2;

  // angle path: Q30 angles, 64-bit vectoring datapath normalized below bit 60
  localparam int ANG_BITS     = 30;
  localparam int ZW           = 34;
  localparam int CW           = 64;
  localparam int NORM_TOP     = 60;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_ITERS = 32;
  localparam int CORDIC_LAT   = NORM_STEPS + CORDIC_ITERS;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
    34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
    34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
    34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
    34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
    34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002,
    34'sh00000001, 34'sh00000000
  };

endpackage

/* sv/cna_div.sv */
// pipelined restoring divider, one quotient bit per stage, two numerators over one divisor
module cna_div #(
  parameter int WORD_BITS = cna_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF,
  parameter int STAGES    = WORD_BITS + 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [2*WORD_BITS:0]     mag_re,
  input  logic [2*WORD_BITS:0]     mag_im,
  input  logic [2*WORD_BITS-1:0]   den,
  output logic [WORD_BITS-1:0]     q_re,
  output logic [WORD_BITS-1:0]     q_im,
  output logic                     ovf_re,
  output logic                     ovf_im
);
  import cna_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int RW = 2*W + 1 + ((F > W) ? F : W);

  logic [RW-1:0]    rem_r [1:STAGES];
  logic [RW-1:0]    rem_i [1:STAGES];
  logic [2*W-1:0]   d     [1:STAGES];
  logic [W-1:0]     qr    [1:STAGES];
  logic [W-1:0]     qi    [1:STAGES];
  logic             ovr   [1:STAGES];
  logic             ovi   [1:STAGES];

  for (genvar k = 1; k <= STAGES; k++) begin : g_stage
    if (k == 1) begin : g_first
      // scale numerators, flag quotients that cannot fit the word
      logic [RW-1:0] nr, ni, dw;
      assign nr = RW'({mag_re, {F{1'b0}}});
      assign ni = RW'({mag_im, {F{1'b0}}});
      assign dw = RW'(den) << W;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= nr;
          rem_i[k] <= ni;
          d[k]     <= den;
          qr[k]    <= '0;
          qi[k]    <= '0;
          ovr[k]   <= (nr >= dw);
          ovi[k]   <= (ni >= dw);
        end
      end
    end else if (k <= W + 1) begin : g_bit
      // trial subtract of the shifted divisor
      localparam int B = W + 1 - k;
      logic [RW-1:0] ds;
      assign ds = RW'(d[k-1]) << B;
      always_ff @(posedge clk) begin
        if (en) begin
          d[k]   <= d[k-1];
          ovr[k] <= ovr[k-1];
          ovi[k] <= ovi[k-1];
          if (rem_r[k-1] >= ds) begin
            rem_r[k] <= rem_r[k-1] - ds;
            qr[k]    <= qr[k-1] | (W'(1) << B);
          end else begin
            rem_r[k] <= rem_r[k-1];
            qr[k]    <= qr[k-1];
          end
          if (rem_i[k-1] >= ds) begin
            rem_i[k] <= rem_i[k-1] - ds;
            qi[k]    <= qi[k-1] | (W'(1) << B);
          end else begin
            rem_i[k] <= rem_i[k-1];
            qi[k]    <= qi[k-1];
          end
        end
      end
    end else begin : g_pass
      // alignment stages
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_r[k-1];
          rem_i[k] <= rem_i[k-1];
          d[k]     <= d[k-1];
          qr[k]    <= qr[k-1];
          qi[k]    <= qi[k-1];
          ovr[k]   <= ovr[k-1];
          ovi[k]   <= ovi[k-1];
        end
      end
    end
  end

  assign q_re   = qr[STAGES];
  assign q_im   = qi[STAGES];
  assign ovf_re = ovr[STAGES];
  assign ovf_im = ovi[STAGES];

endmodule

/* sv/cna_sqrt.sv */
// pipelined integer square root, one root bit per stage
module cna_sqrt #(
  parameter int WORD_BITS = cna_pkg::WORD_BITS_DEF,
  parameter int STAGES    = WORD_BITS
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2*WORD_BITS-1:0] n,
  output logic [WORD_BITS-1:0]   root
);
  import cna_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int SW = 2*W + 1;

  logic [SW-1:0] rem [1:STAGES];
  logic [W-1:0]  rt  [1:STAGES];

  for (genvar k = 1; k <= STAGES; k++) begin : g_stage
    logic [SW-1:0] prem;
    logic [W-1:0]  prt;
    if (k == 1) begin : g_src
      assign prem = SW'(n);
      assign prt  = '0;
    end else begin : g_chain
      assign prem = rem[k-1];
      assign prt  = rt[k-1];
    end
    if (k <= W) begin : g_bit
      // test root bit against the remaining radicand
      localparam int B = W - k;
      logic [SW-1:0] t;
      assign t = (SW'(prt) << (B + 1)) + (SW'(1) << (2*B));
      always_ff @(posedge clk) begin
        if (en) begin
          if (t <= prem) begin
            rem[k] <= prem - t;
            rt[k]  <= prt | (W'(1) << B);
          end else begin
            rem[k] <= prem;
            rt[k]  <= prt;
          end
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= prem;
          rt[k]  <= prt;
        end
      end
    end
  end

  assign root = rt[STAGES];

endmodule

/* sv/cna_cordic.sv */
// pipelined vectoring cordic: normalize stages then one rotation per stage
module cna_cordic #(
  parameter int WORD_BITS = cna_pkg::WORD_BITS_DEF,
  parameter int STAGES    = cna_pkg::CORDIC_LAT
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [WORD_BITS-1:0]          x_in,
  input  logic [WORD_BITS-1:0]          y_in,
  output logic signed [cna_pkg::ZW-1:0] z_out
);
  import cna_pkg::*;

  logic signed [CW-1:0] x [1:STAGES];
  logic signed [CW-1:0] y [1:STAGES];
  logic signed [ZW-1:0] z [1:STAGES];

  for (genvar k = 1; k <= STAGES; k++) begin : g_stage
    logic signed [CW-1:0] px, py;
    logic signed [ZW-1:0] pz;
    if (k == 1) begin : g_src
      assign px = signed'(CW'(x_in));
      assign py = signed'(CW'(y_in));
      assign pz = '0;
    end else begin : g_chain
      assign px = x[k-1];
      assign py = y[k-1];
      assign pz = z[k-1];
    end
    if (k <= NORM_STEPS) begin : g_norm
      // binary search shift until the larger value reaches the top bit
      localparam int SH = 32 >> (k - 1);
      logic [CW-1:0] v;
      assign v = px | py;
      always_ff @(posedge clk) begin
        if (en) begin
          if (v[NORM_TOP-1 -: SH] == '0) begin
            x[k] <= px <<< SH;
            y[k] <= py <<< SH;
          end else begin
            x[k] <= px;
            y[k] <= py;
          end
          z[k] <= pz;
        end
      end
    end else if (k <= NORM_STEPS + CORDIC_ITERS) begin : g_iter
      // rotate toward the x axis and accumulate the angle
      localparam int I = k - NORM_STEPS - 1;
      logic signed [CW-1:0] dx, dy;
      assign dx = py >>> I;
      assign dy = px >>> I;
      always_ff @(posedge clk) begin
        if (en) begin
          if (!py[CW-1]) begin
            x[k] <= px + dx;
            y[k] <= py - dy;
            z[k] <= pz + ATAN_TAB[I];
          end else begin
            x[k] <= px - dx;
            y[k] <= py + dy;
            z[k] <= pz - ATAN_TAB[I];
          end
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          x[k] <= px;
          y[k] <= py;
          z[k] <= pz;
        end
      end
    end
  end

  assign z_out = z[STAGES];

endmodule

/* sv/complex_number_alu.sv */
// complex arithmetic unit in signed fixed point: front stages, divider, root, cordic, output
// throughput: one beat per cycle while the skid is empty; the depth is set by the cordic
// chain (6 normalize stages, 32 rotations) or the bit-per-stage divider, whichever is longer
// the output register plus a one-beat skid keep input accepted while one result waits; a full skid stalls input
// rst is synchronous and active high; it clears only the valid bits, m_tvalid and skid_v
`include "complex_number_alu_defines.svh"

module complex_number_alu #(
  parameter int WORD_BITS = cna_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // a_real, a_imag, b_real, b_imag
  input  logic [((4*WORD_BITS+7)/8)*8-1:0]          s_tdata,
  // operation
  input  logic [cna_pkg::OP_W-1:0]                  s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // res_real, res_imag
  output logic [((2*WORD_BITS+7)/8)*8-1:0]          m_tdata,
  // compare_true, status
  output logic [cna_pkg::ST_W:0]                    m_tuser
);
  import cna_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int PW     = 2*W;
  localparam int XW     = 2*W + F + 2;
  localparam int AW     = ZW + 2;
  localparam int SHR    = ANG_BITS - F;
  localparam int DIVLAT = W + 1;
  localparam int STAGES = (DIVLAT > CORDIC_LAT) ? DIVLAT : CORDIC_LAT;
  localparam int MDW    = ((2*W+7)/8)*8;

  localparam logic signed [XW-1:0] WMAX_X = signed'({{(XW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [XW-1:0] WMIN_X = -WMAX_X - XW'(1);

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic signed [W-1:0] rr;
    logic signed [W-1:0] ri;
    logic                cmp;
    logic                sat;
    logic                den_zero;
    logic                neg_re;
    logic                neg_im;
    logic                re_zero;
    logic                im_zero;
    logic                re_neg;
    logic                im_neg;
  } side_t;

  typedef struct packed {
    logic signed [W-1:0] rr;
    logic signed [W-1:0] ri;
    logic                cmp;
    logic [ST_W-1:0]     st;
  } res_t;

  // saturate to the word, flag in the top bit
  function automatic logic [W:0] sat_x(input logic signed [XW-1:0] v);
    logic [W:0] r;
    if (v > WMAX_X)      r = {1'b1, WMAX_X[W-1:0]};
    else if (v < WMIN_X) r = {1'b1, WMIN_X[W-1:0]};
    else                 r = {1'b0, v[W-1:0]};
    return r;
  endfunction

  logic en;
  logic skid_v;

  // stage 1: input register
  logic                v1;
  logic [OP_W-1:0]     op1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;

  assign en       = !skid_v;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= s_tuser;
      ar1 <= s_tdata[W-1:0];
      ai1 <= s_tdata[2*W-1:W];
      br1 <= s_tdata[3*W-1:2*W];
      bi1 <= s_tdata[4*W-1:3*W];
    end
  end

  // stage 2: partial products
  logic                 v2;
  logic [OP_W-1:0]      op2;
  logic signed [W-1:0]  ar2, ai2, br2, bi2;
  logic signed [PW-1:0] p_arbr, p_aibi, p_arbi, p_aibr, p_arar, p_aiai, p_brbr, p_bibi;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2    <= op1;
      ar2    <= ar1;
      ai2    <= ai1;
      br2    <= br1;
      bi2    <= bi1;
      p_arbr <= ar1 * br1;
      p_aibi <= ai1 * bi1;
      p_arbi <= ar1 * bi1;
      p_aibr <= ai1 * br1;
      p_arar <= ar1 * ar1;
      p_aiai <= ai1 * ai1;
      p_brbr <= br1 * br1;
      p_bibi <= bi1 * bi1;
    end
  end

  // stage 3: sums of products and the short operations
  logic                 v3;
  logic [OP_W-1:0]      op3;
  logic signed [W-1:0]  ar3, ai3;
  logic signed [PW:0]   mulr3, muli3, dnr3, dni3;
  logic [PW-1:0]        maga3, magb3;
  logic [W:0]           sr3, si3;
  logic                 eq3;
  logic [W:0]           sr_c, si_c;

  always_comb begin
    logic signed [XW-1:0] xar, xai, xbr, xbi, one_x;
    xar   = XW'(ar2);
    xai   = XW'(ai2);
    xbr   = XW'(br2);
    xbi   = XW'(bi2);
    one_x = signed'(XW'(1)) <<< F;
    case (op2)
      OP_ADD: begin
        sr_c = sat_x(xar + xbr);
        si_c = sat_x(xai + xbi);
      end
      OP_SUB: begin
        sr_c = sat_x(xar - xbr);
        si_c = sat_x(xai - xbi);
      end
      OP_NEG: begin
        sr_c = sat_x(-xar);
        si_c = sat_x(-xai);
      end
      OP_INC: begin
        sr_c = sat_x(xar + one_x);
        si_c = sat_x(xai + one_x);
      end
      OP_DEC: begin
        sr_c = sat_x(xar - one_x);
        si_c = sat_x(xai - one_x);
      end
      default: begin
        sr_c = '0;
        si_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3   <= op2;
      ar3   <= ar2;
      ai3   <= ai2;
      mulr3 <= (PW+1)'(p_arbr) - (PW+1)'(p_aibi);
      muli3 <= (PW+1)'(p_arbi) + (PW+1)'(p_aibr);
      dnr3  <= (PW+1)'(p_arbr) + (PW+1)'(p_aibi);
      dni3  <= (PW+1)'(p_aibr) - (PW+1)'(p_arbi);
      maga3 <= unsigned'(p_arar) + unsigned'(p_aiai);
      magb3 <= unsigned'(p_brbr) + unsigned'(p_bibi);
      sr3   <= sr_c;
      si3   <= si_c;
      eq3   <= (ar2 == br2) && (ai2 == bi2);
    end
  end

  // stage 4: product scaling, compares, operand prep for the long units
  logic           v4;
  side_t          side4;
  logic [PW:0]    mag_re4, mag_im4;
  logic [PW-1:0]  den4, n4;
  logic [W-1:0]   x4, y4;
  side_t          side_c;

  always_comb begin
    logic [W:0] mr, mi;
    mr = sat_x(XW'(mulr3 >>> F));
    mi = sat_x(XW'(muli3 >>> F));
    side_c.op       = op3;
    side_c.den_zero = (magb3 == '0);
    side_c.neg_re   = dnr3[PW];
    side_c.neg_im   = dni3[PW];
    side_c.re_zero  = (ar3 == '0);
    side_c.im_zero  = (ai3 == '0);
    side_c.re_neg   = ar3[W-1];
    side_c.im_neg   = ai3[W-1];
    if (op3 == OP_MUL) begin
      side_c.rr  = mr[W-1:0];
      side_c.ri  = mi[W-1:0];
      side_c.sat = mr[W] | mi[W];
    end else begin
      side_c.rr  = sr3[W-1:0];
      side_c.ri  = si3[W-1:0];
      side_c.sat = sr3[W] | si3[W];
    end
    case (op3)
      OP_GT:   side_c.cmp = maga3 > magb3;
      OP_LT:   side_c.cmp = maga3 < magb3;
      OP_GE:   side_c.cmp = maga3 >= magb3;
      OP_LE:   side_c.cmp = maga3 <= magb3;
      OP_EQ:   side_c.cmp = eq3;
      OP_NE:   side_c.cmp = !eq3;
      default: side_c.cmp = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4   <= side_c;
      mag_re4 <= dnr3[PW] ? unsigned'(-dnr3) : unsigned'(dnr3);
      mag_im4 <= dni3[PW] ? unsigned'(-dni3) : unsigned'(dni3);
      den4    <= magb3;
      n4      <= maga3;
      x4      <= ar3[W-1] ? unsigned'(-ar3) : unsigned'(ar3);
      y4      <= ai3[W-1] ? unsigned'(-ai3) : unsigned'(ai3);
    end
  end

  // long units, all of the same depth
  logic [W-1:0]         q_re, q_im, root;
  logic                 ovf_re, ovf_im;
  logic signed [ZW-1:0] z;

  cna_div #(.WORD_BITS(W), .FRAC_BITS(F), .STAGES(STAGES)) u_div (
    .clk    (clk),
    .en     (en),
    .mag_re (mag_re4),
    .mag_im (mag_im4),
    .den    (den4),
    .q_re   (q_re),
    .q_im   (q_im),
    .ovf_re (ovf_re),
    .ovf_im (ovf_im)
  );

  cna_sqrt #(.WORD_BITS(W), .STAGES(STAGES)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    (n4),
    .root (root)
  );

  cna_cordic #(.WORD_BITS(W), .STAGES(STAGES)) u_cordic (
    .clk   (clk),
    .en    (en),
    .x_in  (x4),
    .y_in  (y4),
    .z_out (z)
  );

  // side data and valid bits alongside the units
  side_t side_d [1:STAGES];
  logic  vi     [1:STAGES];

  for (genvar k = 1; k <= STAGES; k++) begin : g_side
    logic  vp;
    side_t sp;
    if (k == 1) begin : g_src
      assign vp = v4;
      assign sp = side4;
    end else begin : g_chain
      assign vp = vi[k-1];
      assign sp = side_d[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vi[k] <= 1'b0;
      end else if (en) begin
        vi[k] <= vp;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side_d[k] <= sp;
      end
    end
  end

  // final select: quotient sign, root and angle placement, status
  res_t  fin;
  side_t sl;

  assign sl = side_d[STAGES];

  always_comb begin
    logic [W:0]           dr, di, ab, ag;
    logic signed [ZW-1:0] t;
    logic signed [AW-1:0] a, rnd;
    logic                 im_pos;
    if (ovf_re)
      dr = {1'b1, sl.neg_re ? WMIN_X[W-1:0] : WMAX_X[W-1:0]};
    else
      dr = sat_x(sl.neg_re ? -signed'(XW'(q_re)) : signed'(XW'(q_re)));
    if (ovf_im)
      di = {1'b1, sl.neg_im ? WMIN_X[W-1:0] : WMAX_X[W-1:0]};
    else
      di = sat_x(sl.neg_im ? -signed'(XW'(q_im)) : signed'(XW'(q_im)));
    ab = sat_x(signed'(XW'(root)));
    if (z < 0)                t = '0;
    else if (z > HALF_PI_Q30) t = HALF_PI_Q30;
    else                      t = z;
    im_pos = !sl.im_neg && !sl.im_zero;
    if (sl.re_zero)
      a = im_pos ? AW'(HALF_PI_Q30) : (sl.im_neg ? -AW'(HALF_PI_Q30) : '0);
    else if (sl.im_zero)
      a = sl.re_neg ? AW'(PI_Q30) : '0;
    else if (!sl.re_neg)
      a = im_pos ? AW'(t) : -AW'(t);
    else
      a = im_pos ? AW'(PI_Q30) - AW'(t) : AW'(t) - AW'(PI_Q30);
    rnd = (a + (signed'(AW'(1)) <<< (SHR - 1))) >>> SHR;
    ag  = sat_x(XW'(rnd));
    fin.cmp = 1'b0;
    case (sl.op)
      OP_DIV: begin
        if (sl.den_zero) begin
          fin.rr = '0;
          fin.ri = '0;
          fin.st = ST_DIVZ;
        end else begin
          fin.rr = dr[W-1:0];
          fin.ri = di[W-1:0];
          fin.st = (dr[W] | di[W]) ? ST_SAT : ST_OK;
        end
      end
      OP_ABS: begin
        fin.rr = ab[W-1:0];
        fin.ri = '0;
        fin.st = ab[W] ? ST_SAT : ST_OK;
      end
      OP_ARG: begin
        fin.rr = ag[W-1:0];
        fin.ri = '0;
        fin.st = ag[W] ? ST_SAT : ST_OK;
      end
      default: begin
        fin.rr  = sl.rr;
        fin.ri  = sl.ri;
        fin.cmp = sl.cmp;
        fin.st  = sl.sat ? ST_SAT : ST_OK;
      end
    endcase
  end

  // output register with a one-beat skid
  res_t out_r, skid;
  logic push;

  assign push = en && vi[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= skid_v || push;
      skid_v   <= 1'b0;
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_r <= skid_v ? skid : fin;
    end else if (push) begin
      skid <= fin;
    end
  end

  assign m_tdata = MDW'({out_r.ri, out_r.rr});
  assign m_tuser = {out_r.st, out_r.cmp};

  `CNA_ASSERT_IMP(a_skid_out, skid_v, m_tvalid)
  `CNA_ASSERT_IMP(a_skid_stall, skid_v, !s_tready)
  `CNA_ASSERT_IMP(a_divz_zero, m_tvalid && m_tuser[ST_W:1] == ST_DIVZ, m_tdata == '0)
  `CNA_ASSERT_IMP(a_cmp_clean, m_tvalid && m_tuser[0], m_tdata == '0 && m_tuser[ST_W:1] == ST_OK)
  `CNA_ASSERT_NXT(a_no_drop, vi[STAGES] && en, m_tvalid)

endmodule

/* verif/tb_complex_number_alu.sv */
// self-checking testbench of the complex arithmetic unit: directed cases, random phases, backpressure
module tb_complex_number_alu;
  import cna_pkg::*;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam longint WMAX = 64'sh7FFF_FFFF;
  localparam longint WMIN = -64'sh8000_0000;
  localparam int LATENCY = 43;

  typedef struct packed {
    logic [WB-1:0] re;
    logic [WB-1:0] im;
    logic          cmp;
    logic [1:0]    st;
  } alu_result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [127:0]  s_tdata = '0;
  logic [OP_W-1:0] s_tuser = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [63:0]   m_tdata;
  logic [ST_W:0] m_tuser;

  alu_result_t expected_results[$];
  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  bit  failed = 1'b0;

  complex_number_alu dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  // ---------------- prediction ----------------

  // clamp to the word range, flag when clamped
  function automatic logic [WB-1:0] clamp_word(input logic signed [127:0] v, inout bit s);
    if (v > WMAX) begin
      s = 1'b1;
      return WMAX[WB-1:0];
    end
    if (v < WMIN) begin
      s = 1'b1;
      return WMIN[WB-1:0];
    end
    return v[WB-1:0];
  endfunction

  function automatic logic signed [127:0] mag_sq(input longint re, input longint im);
    logic signed [127:0] r, i;
    r = re;
    i = im;
    return r * r + i * i;
  endfunction

  function automatic longint floor_sqrt(input logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return longint'(r);
  endfunction

  // vectoring cordic on a first-quadrant point, angle in Q30
  function automatic longint first_quadrant_angle(input longint x0, input longint y0);
    logic [63:0] ux, uy;
    longint x, y, z, dx, dy;
    ux = x0;
    uy = y0;
    z = 0;
    while ((ux | uy) < (64'd1 << 59)) begin
      ux = ux << 1;
      uy = uy << 1;
    end
    x = ux;
    y = uy;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q30)) z = HALF_PI_Q30;
    return z;
  endfunction

  function automatic longint angle_q30(input longint re, input longint im);
    longint t;
    if (re == 0) return im > 0 ? longint'(HALF_PI_Q30) : (im < 0 ? -longint'(HALF_PI_Q30) : 0);
    if (im == 0) return re > 0 ? 0 : longint'(PI_Q30);
    t = first_quadrant_angle(re < 0 ? -re : re, im < 0 ? -im : im);
    if (re > 0) return im > 0 ? t : -t;
    return im > 0 ? longint'(PI_Q30) - t : t - longint'(PI_Q30);
  endfunction

  function automatic alu_result_t predict_alu(input logic [OP_W-1:0] op,
      input logic [WB-1:0] a_re, input logic [WB-1:0] a_im,
      input logic [WB-1:0] b_re, input logic [WB-1:0] b_im);
    alu_result_t r;
    longint ar, ai, br, bi, ang;
    logic signed [127:0] one, den, num, ma, mb;
    bit s;
    ar = longint'(signed'(a_re));
    ai = longint'(signed'(a_im));
    br = longint'(signed'(b_re));
    bi = longint'(signed'(b_im));
    one = 128'sd1 <<< FB;
    r = '0;
    s = 1'b0;
    case (op)
      OP_ADD: begin
        r.re = clamp_word(ar + br, s); r.im = clamp_word(ai + bi, s);
      end
      OP_SUB: begin
        r.re = clamp_word(ar - br, s); r.im = clamp_word(ai - bi, s);
      end
      OP_NEG: begin
        r.re = clamp_word(-ar, s); r.im = clamp_word(-ai, s);
      end
      OP_MUL: begin
        r.re = clamp_word((128'(ar) * br - 128'(ai) * bi) >>> FB, s);
        r.im = clamp_word((128'(ar) * bi + 128'(ai) * br) >>> FB, s);
      end
      OP_DIV: begin
        den = mag_sq(br, bi);
        if (den == 0) begin
          r.st = ST_DIVZ;
        end else begin
          num = (128'(ar) * br + 128'(ai) * bi) <<< FB;
          r.re = clamp_word(num / den, s);
          num = (128'(ai) * br - 128'(ar) * bi) <<< FB;
          r.im = clamp_word(num / den, s);
        end
      end
      OP_ABS: r.re = clamp_word(floor_sqrt(mag_sq(ar, ai)), s);
      OP_ARG: begin
        ang = angle_q30(ar, ai);
        ang = (ang + (64'sd1 <<< (ANG_BITS - FB - 1))) >>> (ANG_BITS - FB);
        r.re = clamp_word(ang, s);
      end
      OP_INC: begin
        r.re = clamp_word(ar + one, s); r.im = clamp_word(ai + one, s);
      end
      OP_DEC: begin
        r.re = clamp_word(ar - one, s); r.im = clamp_word(ai - one, s);
      end
      OP_GT, OP_LT, OP_GE, OP_LE: begin
        ma = mag_sq(ar, ai);
        mb = mag_sq(br, bi);
        case (op)
          OP_GT:   r.cmp = ma > mb;
          OP_LT:   r.cmp = ma < mb;
          OP_GE:   r.cmp = ma >= mb;
          default: r.cmp = ma <= mb;
        endcase
      end
      OP_EQ: r.cmp = (ar == br) && (ai == bi);
      OP_NE: r.cmp = !((ar == br) && (ai == bi));
      default: ;
    endcase
    if (s) r.st = ST_SAT;
    return r;
  endfunction

  // ---------------- stimulus ----------------

  // offer one beat, random idle cycles first
  task automatic send_item(input logic [OP_W-1:0] op, input logic [WB-1:0] a_re,
      input logic [WB-1:0] a_im, input logic [WB-1:0] b_re, input logic [WB-1:0] b_im);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {b_im, b_re, a_im, a_re};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_alu(op, a_re, a_im, b_re, b_im));
  endtask

  // mix of extremes, small fixed-point values and raw random words
  function automatic logic [WB-1:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 8 << FB)) - (4 << FB));
      3: return 32'(signed'($urandom_range(0, 65535)) - 32768);
      4: return $urandom_range(2) == 0 ? 32'd0 : 32'(signed'($urandom_range(2)) - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int n);
    logic [WB-1:0] br, bi;
    for (int k = 0; k < n; k++) begin
      br = pick_word();
      bi = pick_word();
      if ($urandom_range(9) == 0) begin
        br = '0; bi = '0;
      end
      send_item(4'($urandom_range(15)), pick_word(), pick_word(), br, bi);
    end
  endtask

  task automatic test_directed();
    logic [WB-1:0] mx, mn, one;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    one = 32'h0001_0000;
    tx_idle_pct = 0; rx_stall_pct = 0;
    send_item(OP_ADD, mx, mn, mx, mn);
    send_item(OP_SUB, mn, mx, mx, mn);
    send_item(OP_NEG, mn, mx, 0, 0);
    send_item(OP_MUL, mx, mx, mx, mx);
    send_item(OP_MUL, mn, mn, mn, mx);
    send_item(OP_MUL, 32'hFFFF_8000, one, one, 32'hFFFF_FFFF);
    send_item(OP_DIV, one, one, 0, 0);
    send_item(OP_DIV, 32'h0003_0000, 32'hFFFE_0000, one, 32'h0002_0000);
    send_item(OP_DIV, mx, mn, 1, 0);
    send_item(OP_ABS, mn, mn, 0, 0);
    send_item(OP_ABS, 32'h0003_0000, 32'h0004_0000, 0, 0);
    send_item(OP_ARG, 0, 0, 0, 0);
    send_item(OP_ARG, 0, one, 0, 0);
    send_item(OP_ARG, 0, mn, 0, 0);
    send_item(OP_ARG, mn, 0, 0, 0);
    send_item(OP_ARG, 32'hFFFF_0000, 32'hFFFF_0000, 0, 0);
    send_item(OP_ARG, mx, 1, 0, 0);
    send_item(OP_INC, mx, 0, 0, 0);
    send_item(OP_DEC, mn, 0, 0, 0);
    send_item(OP_GT, one, 0, 0, one);
    send_item(OP_LT, mn, 0, 0, mx);
    send_item(OP_GE, one, 0, 0, one);
    send_item(OP_LE, mx, mx, mn, mn);
    send_item(OP_EQ, one, mn, one, mn);
    send_item(OP_NE, one, mn, one, mn);
    send_item(4'hF, mx, mn, mx, mn);
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    send_random(n);
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b1;
    send_random(90);
  endtask

  // ---------------- receiver and checking ----------------

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt <= 400;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= rx_stall_pct;
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    alu_result_t exp_r, got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[2:1]};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat: actual %h", $realtime, got);
        failed = 1'b1;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.re !== exp_r.re)
          $display("%0t: res_real mismatch: expected %h actual %h", $realtime, exp_r.re, got.re);
        if (got.im !== exp_r.im)
          $display("%0t: res_imag mismatch: expected %h actual %h", $realtime, exp_r.im, got.im);
        if (got.cmp !== exp_r.cmp)
          $display("%0t: compare mismatch: expected %b actual %b", $realtime, exp_r.cmp, got.cmp);
        if (got.st !== exp_r.st)
          $display("%0t: status mismatch: expected %0d actual %0d", $realtime, exp_r.st, got.st);
        if (got !== exp_r) failed = 1'b1;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 0, 200);
    test_random_phase(86, 0, 150);
    test_random_phase(0, 86, 150);
    test_random_phase(24, 24, 200);
    test_backpressure();
    test_random_phase(0, 0, 60);
    s_tvalid <= 1'b0;
    rx_stall_pct = 0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (!failed && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("tb: failure");
    $finish;
  end

endmodule
